// File: hw/rtl/nmh_pkg.sv
// ----------------------------------------------------------------------------
// nmh_pkg: shared types and constants of the normal map unit
// Holds the store geometry, the request and result formats, the register
// indexes, the sequencer states and the neighbor weight tables.
// ----------------------------------------------------------------------------
package nmh_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int HS_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int HS_AW      = $clog2(HS_DEPTH);

    localparam int POS_W      = 8;
    localparam int SAMP_W     = 16;
    localparam int DIM_W      = 9;
    localparam int DIM_CMP_W  = 14;
    localparam int SCALE_W    = 16;
    localparam int GRAD_W     = 21;
    localparam int MAG_W      = 30;
    localparam int AMP_W      = 35;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int D_W        = 28;
    localparam int ROOT_W     = 64;
    localparam int DIVN_W     = 40;
    localparam int DIVD_W     = 32;
    localparam int QUOT_W     = 9;
    localparam int UNORM_W    = 8;

    typedef struct packed {
        logic                mode;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [SAMP_W-1:0]   height_sample;
    } t_req;

    typedef struct packed {
        logic [UNORM_W-1:0]  normal_r;
        logic [UNORM_W-1:0]  normal_g;
        logic [UNORM_W-1:0]  normal_b;
    } t_res;

    typedef struct packed {
        logic                start;
        logic [DIVN_W-1:0]   dividend;
        logic [DIVD_W-1:0]   divisor;
    } t_div_req;

    typedef enum logic [2:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_FRAME_HEIGHT  = 3'd1,
        CFG_EDGE_REPEAT   = 3'd2,
        CFG_USE_SOBEL     = 3'd3,
        CFG_LEFT_HANDED   = 3'd4,
        CFG_DIRECTX       = 3'd5,
        CFG_SLOPE_SCALE   = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODX_START,
        ST_MODX_WAIT,
        ST_MODY_START,
        ST_MODY_WAIT,
        ST_COORD,
        ST_READ,
        ST_MUL,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_UN_START,
        ST_UN_WAIT,
        ST_OUT
    } t_state;

    // Neighbor order: top-left, top, top-right, left, right,
    // bottom-left, bottom, bottom-right. Column and row codes select
    // minus, center or plus.
    function automatic logic [1:0] nbr_col(input logic [2:0] idx);
        logic [1:0] c;
        unique case (idx)
            3'd0, 3'd3, 3'd5: c = 2'd0;
            3'd1, 3'd6:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] nbr_row(input logic [2:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic signed [3:0] nbr_wx(input logic [2:0] idx, input logic sobel);
        logic signed [3:0] w;
        unique case (idx)
            3'd0, 3'd5: w = sobel ? -4'sd1 : 4'sd0;
            3'd2, 3'd7: w = sobel ?  4'sd1 : 4'sd0;
            3'd3:       w = sobel ? -4'sd2 : -4'sd4;
            3'd4:       w = sobel ?  4'sd2 :  4'sd4;
            default:    w = 4'sd0;
        endcase
        return w;
    endfunction

    function automatic logic signed [3:0] nbr_wy(input logic [2:0] idx, input logic sobel);
        logic signed [3:0] w;
        unique case (idx)
            3'd0, 3'd2: w = sobel ? -4'sd1 : 4'sd0;
            3'd5, 3'd7: w = sobel ?  4'sd1 : 4'sd0;
            3'd1:       w = sobel ? -4'sd2 : -4'sd4;
            3'd6:       w = sobel ?  4'sd2 :  4'sd4;
            default:    w = 4'sd0;
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/nmh_div.sv
// ----------------------------------------------------------------------------
// nmh_div: restoring divider with a nine-bit quotient
// One quotient bit per cycle. The caller guarantees that the quotient fits
// in nine bits; the remainder is valid with the quotient.
// ----------------------------------------------------------------------------
module nmh_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nmh_pkg::t_div_req               i_req,
    output logic                            o_done,
    output logic [nmh_pkg::QUOT_W-1:0]      o_quot,
    output logic [nmh_pkg::DIVD_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(nmh_pkg::QUOT_W);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [nmh_pkg::DIVD_W-1:0]     r_rem;
    logic [nmh_pkg::DIVD_W-1:0]     r_div;
    logic [nmh_pkg::QUOT_W-1:0]     r_q;

    logic [nmh_pkg::DIVD_W:0]       trial;
    logic [nmh_pkg::DIVD_W:0]       diff;
    logic                           ge;

    assign trial = {r_rem, r_q[nmh_pkg::QUOT_W-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
        end else if (r_busy && r_cnt == CNT_W'(nmh_pkg::QUOT_W - 1)) begin
            n_busy = 1'b0;
            n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            if (i_req.start) begin
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // The high dividend bits seed the remainder; the low bits shift through
    // the quotient register and are replaced by quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= nmh_pkg::DIVD_W'(i_req.dividend[nmh_pkg::DIVN_W-1:nmh_pkg::QUOT_W]);
            r_q   <= i_req.dividend[nmh_pkg::QUOT_W-1:0];
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[nmh_pkg::DIVD_W-1:0] : trial[nmh_pkg::DIVD_W-1:0];
            r_q   <= {r_q[nmh_pkg::QUOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/normal_map_from_height_unit.sv
// ----------------------------------------------------------------------------
// normal_map_from_height_unit: tangent-space normals from a stored height map
// Height writes go to an on-chip store; compute requests read the eight
// neighbors of the 3x3 neighborhood and run gradient, scaling, normalization
// and unorm mapping on one multiplier, one square-root step and one shared divider.
// ----------------------------------------------------------------------------
// A write request is stored on acceptance and busy stays low.
// A compute request keeps busy high until the result strobe, which comes in its
// last busy cycle; with wrap two modulo divisions come first. The 32-step square
// root, three divisions and a data-dependent normalizing shift follow the reads.
// One request at a time: busy is high from acceptance until the result strobe.
// Reset clears the control state and the configuration registers; the height store is not
// cleared and an entry must be written before it is read.
// ----------------------------------------------------------------------------
module normal_map_from_height_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  nmh_pkg::t_req           i_req,
    output logic                    o_done,
    output nmh_pkg::t_res           o_res,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [nmh_pkg::SCALE_W-1:0] i_cfg_data
);

    localparam int POS_W  = nmh_pkg::POS_W;
    localparam int DIM_W  = nmh_pkg::DIM_W;
    localparam int CMP_W  = nmh_pkg::DIM_CMP_W;
    localparam int AW     = nmh_pkg::HS_AW;

    // Configuration
    logic [DIM_W-1:0]               r_cfg_w, r_cfg_h;
    logic                           r_cfg_wrap, r_cfg_sobel, r_cfg_left, r_cfg_dx;
    logic [nmh_pkg::SCALE_W-1:0]    r_cfg_scale;

    // Sequencer
    nmh_pkg::t_state                r_state, n_state;
    logic [4:0]                     r_cnt;
    logic [1:0]                     r_comp;

    // Datapath
    logic [POS_W-1:0]               r_bx, r_by;
    logic [POS_W-1:0]               r_cx [3];
    logic [POS_W-1:0]               r_cy [3];
    logic [nmh_pkg::SAMP_W-1:0]     r_mem [nmh_pkg::HS_DEPTH];
    logic [nmh_pkg::SAMP_W-1:0]     r_mem_q;
    logic signed [nmh_pkg::GRAD_W-1:0] r_gx, r_gy;
    logic [nmh_pkg::AMP_W-1:0]      r_ux, r_uy;
    logic [nmh_pkg::D_W-1:0]        r_d;
    logic                           r_negx, r_negy;
    logic [nmh_pkg::PROD_W-1:0]     r_prod;
    logic [nmh_pkg::ROOT_W-1:0]     r_acc, r_v, r_root, r_bit;
    nmh_pkg::t_res                  r_res;

    // Combinational
    logic                           accept;
    logic [DIM_W-1:0]               eff_w, eff_h;
    logic [nmh_pkg::MAG_W-1:0]      mul_a, mul_b;
    logic [nmh_pkg::MAG_W-1:0]      mag_gx, mag_gy;
    nmh_pkg::t_div_req              div_req;
    logic                           div_done;
    logic [nmh_pkg::QUOT_W-1:0]     div_quot;
    logic [nmh_pkg::DIVD_W-1:0]     div_rem;
    logic [2:0]                     rd_idx, acc_idx;
    logic [AW-1:0]                  rd_addr, wr_addr;
    logic                           wr_in_range;
    logic signed [nmh_pkg::GRAD_W-1:0] term_x, term_y;
    logic                           need_shift;
    logic [nmh_pkg::ROOT_W-1:0]     sq_trial;
    logic [nmh_pkg::MAG_W-1:0]      un_mag;
    logic                           un_neg;
    logic [nmh_pkg::DIVN_W-1:0]     un_m255, un_l256, un_num;
    logic [3*POS_W-1:0]             coord_x, coord_y;

    assign accept = start && !busy;

    // Frame size of zero acts as one; above the store it acts as the store.
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = DIM_W'(1);
        end else if (CMP_W'(r_cfg_w) > CMP_W'(nmh_pkg::MAX_WIDTH)) begin
            eff_w = DIM_W'(nmh_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            eff_h = DIM_W'(1);
        end else if (CMP_W'(r_cfg_h) > CMP_W'(nmh_pkg::MAX_HEIGHT)) begin
            eff_h = DIM_W'(nmh_pkg::MAX_HEIGHT);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    // Minus, center and plus coordinates. With wrap the base is already
    // reduced into the frame; with clamping it is the raw position.
    function automatic logic [3*POS_W-1:0] neighbors(input logic [POS_W-1:0] base,
                                                     input logic [DIM_W-1:0] n,
                                                     input logic wrap);
        logic [DIM_W-1:0] lim, b9, m9, p9;
        logic [POS_W-1:0] m, c, p;
        lim = n - 1'b1;
        b9  = DIM_W'(base);
        m9  = b9 - 1'b1;
        p9  = b9 + 1'b1;
        if (wrap) begin
            m = (base == '0) ? lim[POS_W-1:0] : m9[POS_W-1:0];
            c = base;
            p = (p9 == n) ? '0 : p9[POS_W-1:0];
        end else begin
            m = (base == '0) ? '0 : ((m9 > lim) ? lim[POS_W-1:0] : m9[POS_W-1:0]);
            c = (b9 > lim) ? lim[POS_W-1:0] : base;
            p = (p9 > lim) ? lim[POS_W-1:0] : p9[POS_W-1:0];
        end
        return {p, c, m};
    endfunction

    assign coord_x = neighbors(r_bx, eff_w, r_cfg_wrap);
    assign coord_y = neighbors(r_by, eff_h, r_cfg_wrap);

    // Store addressing
    assign rd_idx  = r_cnt[2:0];
    assign acc_idx = rd_idx - 1'b1;
    assign rd_addr = AW'(r_cy[nmh_pkg::nbr_row(rd_idx)]) * AW'(nmh_pkg::MAX_WIDTH)
                   + AW'(r_cx[nmh_pkg::nbr_col(rd_idx)]);
    assign wr_addr = AW'(i_req.pos_y) * AW'(nmh_pkg::MAX_WIDTH) + AW'(i_req.pos_x);
    assign wr_in_range = (CMP_W'(i_req.pos_x) < CMP_W'(nmh_pkg::MAX_WIDTH))
                      && (CMP_W'(i_req.pos_y) < CMP_W'(nmh_pkg::MAX_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (accept && !i_req.mode && wr_in_range) begin
            r_mem[wr_addr] <= i_req.height_sample;
        end
        if (r_state == nmh_pkg::ST_READ && !r_cnt[3]) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    assign term_x = nmh_pkg::GRAD_W'(
        $signed({{(nmh_pkg::GRAD_W-nmh_pkg::SAMP_W){1'b0}}, r_mem_q})
        * nmh_pkg::nbr_wx(acc_idx, r_cfg_sobel));
    assign term_y = nmh_pkg::GRAD_W'(
        $signed({{(nmh_pkg::GRAD_W-nmh_pkg::SAMP_W){1'b0}}, r_mem_q})
        * nmh_pkg::nbr_wy(acc_idx, r_cfg_sobel));

    assign mag_gx = nmh_pkg::MAG_W'(r_gx[nmh_pkg::GRAD_W-1] ? -r_gx : r_gx);
    assign mag_gy = nmh_pkg::MAG_W'(r_gy[nmh_pkg::GRAD_W-1] ? -r_gy : r_gy);

    assign need_shift = (|r_ux[nmh_pkg::AMP_W-1:nmh_pkg::MAG_W])
                     || (|r_uy[nmh_pkg::AMP_W-1:nmh_pkg::MAG_W]);

    assign sq_trial = r_root + r_bit;

    // Unorm numerator 256*L + 255*a, floored at zero.
    always_comb begin
        unique case (r_comp)
            2'd0:    begin un_mag = r_ux[nmh_pkg::MAG_W-1:0]; un_neg = r_negx; end
            2'd1:    begin un_mag = r_uy[nmh_pkg::MAG_W-1:0]; un_neg = r_negy; end
            default: begin un_mag = nmh_pkg::MAG_W'(r_d);     un_neg = 1'b0;   end
        endcase
        un_m255 = (nmh_pkg::DIVN_W'(un_mag) << 8) - nmh_pkg::DIVN_W'(un_mag);
        un_l256 = nmh_pkg::DIVN_W'(r_root[nmh_pkg::DIVD_W-2:0]) << 8;
        if (un_neg) begin
            un_num = (un_m255 > un_l256) ? '0 : un_l256 - un_m255;
        end else begin
            un_num = un_l256 + un_m255;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nmh_pkg::ST_IDLE: begin
                if (accept && i_req.mode) begin
                    n_state = r_cfg_wrap ? nmh_pkg::ST_MODX_START : nmh_pkg::ST_COORD;
                end
            end
            nmh_pkg::ST_MODX_START: n_state = nmh_pkg::ST_MODX_WAIT;
            nmh_pkg::ST_MODX_WAIT: begin
                if (div_done) n_state = nmh_pkg::ST_MODY_START;
            end
            nmh_pkg::ST_MODY_START: n_state = nmh_pkg::ST_MODY_WAIT;
            nmh_pkg::ST_MODY_WAIT: begin
                if (div_done) n_state = nmh_pkg::ST_COORD;
            end
            nmh_pkg::ST_COORD: n_state = nmh_pkg::ST_READ;
            nmh_pkg::ST_READ: begin
                if (r_cnt == 5'd8) n_state = nmh_pkg::ST_MUL;
            end
            nmh_pkg::ST_MUL: begin
                if (r_cnt == 5'd2) n_state = nmh_pkg::ST_SHIFT;
            end
            nmh_pkg::ST_SHIFT: begin
                if (!need_shift) n_state = nmh_pkg::ST_SQ;
            end
            nmh_pkg::ST_SQ: begin
                if (r_cnt == 5'd3) n_state = nmh_pkg::ST_SQRT;
            end
            nmh_pkg::ST_SQRT: begin
                if (r_cnt == 5'd31) n_state = nmh_pkg::ST_UN_START;
            end
            nmh_pkg::ST_UN_START: n_state = nmh_pkg::ST_UN_WAIT;
            nmh_pkg::ST_UN_WAIT: begin
                if (div_done) begin
                    n_state = (r_comp == 2'd2) ? nmh_pkg::ST_OUT : nmh_pkg::ST_UN_START;
                end
            end
            nmh_pkg::ST_OUT: n_state = nmh_pkg::ST_IDLE;
            default: n_state = nmh_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, divider request, multiplier operands.
    always_comb begin
        busy     = r_state != nmh_pkg::ST_IDLE;
        o_done   = r_state == nmh_pkg::ST_OUT;
        div_req  = '0;
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_state)
            nmh_pkg::ST_MODX_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = nmh_pkg::DIVN_W'(r_bx);
                div_req.divisor  = nmh_pkg::DIVD_W'(eff_w);
            end
            nmh_pkg::ST_MODY_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = nmh_pkg::DIVN_W'(r_by);
                div_req.divisor  = nmh_pkg::DIVD_W'(eff_h);
            end
            nmh_pkg::ST_UN_START: begin
                div_req.start    = 1'b1;
                div_req.dividend = un_num;
                div_req.divisor  = {r_root[nmh_pkg::DIVD_W-2:0], 1'b0};
            end
            nmh_pkg::ST_MUL: begin
                mul_a = (r_cnt == 5'd0) ? mag_gx : mag_gy;
                mul_b = nmh_pkg::MAG_W'(r_cfg_scale);
            end
            nmh_pkg::ST_SQ: begin
                unique case (r_cnt)
                    5'd0:    begin mul_a = r_ux[nmh_pkg::MAG_W-1:0];
                                   mul_b = r_ux[nmh_pkg::MAG_W-1:0]; end
                    5'd1:    begin mul_a = r_uy[nmh_pkg::MAG_W-1:0];
                                   mul_b = r_uy[nmh_pkg::MAG_W-1:0]; end
                    default: begin mul_a = nmh_pkg::MAG_W'(r_d);
                                   mul_b = nmh_pkg::MAG_W'(r_d); end
                endcase
            end
            default: ;
        endcase
    end

    nmh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nmh_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_cfg_w     <= DIM_W'(256);
            r_cfg_h     <= DIM_W'(256);
            r_cfg_wrap  <= 1'b0;
            r_cfg_sobel <= 1'b1;
            r_cfg_left  <= 1'b0;
            r_cfg_dx    <= 1'b0;
            r_cfg_scale <= nmh_pkg::SCALE_W'(256);
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? '0 : r_cnt + 1'b1;
            if (r_state == nmh_pkg::ST_SQRT) begin
                r_comp <= '0;
            end else if (r_state == nmh_pkg::ST_UN_WAIT && div_done) begin
                r_comp <= r_comp + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (nmh_pkg::t_cfg_idx'(i_cfg_idx))
                    nmh_pkg::CFG_FRAME_WIDTH:  r_cfg_w     <= i_cfg_data[DIM_W-1:0];
                    nmh_pkg::CFG_FRAME_HEIGHT: r_cfg_h     <= i_cfg_data[DIM_W-1:0];
                    nmh_pkg::CFG_EDGE_REPEAT:  r_cfg_wrap  <= i_cfg_data[0];
                    nmh_pkg::CFG_USE_SOBEL:    r_cfg_sobel <= i_cfg_data[0];
                    nmh_pkg::CFG_LEFT_HANDED:  r_cfg_left  <= i_cfg_data[0];
                    nmh_pkg::CFG_DIRECTX:      r_cfg_dx    <= i_cfg_data[0];
                    nmh_pkg::CFG_SLOPE_SCALE:  r_cfg_scale <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            nmh_pkg::ST_IDLE: begin
                r_bx <= i_req.pos_x;
                r_by <= i_req.pos_y;
            end
            nmh_pkg::ST_MODX_WAIT: begin
                if (div_done) r_bx <= div_rem[POS_W-1:0];
            end
            nmh_pkg::ST_MODY_WAIT: begin
                if (div_done) r_by <= div_rem[POS_W-1:0];
            end
            nmh_pkg::ST_COORD: begin
                for (int i = 0; i < 3; i++) begin
                    r_cx[i] <= coord_x[i*POS_W +: POS_W];
                    r_cy[i] <= coord_y[i*POS_W +: POS_W];
                end
                r_gx <= '0;
                r_gy <= '0;
                r_d  <= nmh_pkg::D_W'(1) << 27;
            end
            nmh_pkg::ST_READ: begin
                // Data for the address issued in the previous cycle.
                if (r_cnt != '0) begin
                    r_gx <= r_gx + term_x;
                    r_gy <= r_gy + term_y;
                end
            end
            nmh_pkg::ST_MUL: begin
                r_negx <= r_gx[nmh_pkg::GRAD_W-1] ^ !r_cfg_left;
                r_negy <= r_gy[nmh_pkg::GRAD_W-1] ^ !r_cfg_dx;
                if (r_cnt == 5'd1) r_ux <= r_prod[nmh_pkg::AMP_W-1:0];
                if (r_cnt == 5'd2) r_uy <= r_prod[nmh_pkg::AMP_W-1:0];
            end
            nmh_pkg::ST_SHIFT: begin
                if (need_shift) begin
                    r_ux <= r_ux >> 1;
                    r_uy <= r_uy >> 1;
                    r_d  <= r_d >> 1;
                end
            end
            nmh_pkg::ST_SQ: begin
                if (r_cnt == 5'd1) r_acc <= nmh_pkg::ROOT_W'(r_prod);
                if (r_cnt == 5'd2) r_acc <= r_acc + nmh_pkg::ROOT_W'(r_prod);
                if (r_cnt == 5'd3) begin
                    r_v    <= r_acc + nmh_pkg::ROOT_W'(r_prod);
                    r_root <= '0;
                    r_bit  <= nmh_pkg::ROOT_W'(1) << 62;
                end
            end
            nmh_pkg::ST_SQRT: begin
                if (r_v >= sq_trial) begin
                    r_v    <= r_v - sq_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            nmh_pkg::ST_UN_WAIT: begin
                if (div_done) begin
                    unique case (r_comp)
                        2'd0: r_res.normal_r <= div_quot[8] ? '1 : div_quot[7:0];
                        2'd1: r_res.normal_g <= div_quot[8] ? '1 : div_quot[7:0];
                        default: r_res.normal_b <= div_quot[8] ? '1 : div_quot[7:0];
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_res = r_res;

    // Assertions
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("result strobe not followed by idle");

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> !div_done)
        else $error("divider done right after a new start");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nmh_pkg::ST_UN_START) |-> (r_root != '0))
        else $error("zero vector length before unorm division");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && r_state != nmh_pkg::ST_OUT) |=> busy)
        else $error("sequencer left a compute request before its result");

endmodule
